/* design/open_address_hash_table_assert.svh */
// Assertion macros shared by the hash table RTL.
// No dependencies; included inside module bodies.
`ifndef OPEN_ADDRESS_HASH_TABLE_ASSERT_SVH
`define OPEN_ADDRESS_HASH_TABLE_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define OAHT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define OAHT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

/* design/oaht_pkg.sv */
// Package for the open-address hash table: sizes, codes and request/response types.
// No dependencies.
package oaht_pkg;
	localparam int TableSize = 64;
	localparam int IdxW = $clog2(TableSize);
	localparam int ProbeLimit = TableSize + 8;
	localparam int ProbeW = $clog2(ProbeLimit + 1);
	localparam int FillW = $clog2(TableSize + 1);

	localparam logic [1:0] KIND_INSERT = 2'd0;
	localparam logic [1:0] KIND_LOOKUP = 2'd1;
	localparam logic [1:0] KIND_DELETE = 2'd2;

	localparam logic [1:0] TAG_EMPTY = 2'd0;
	localparam logic [1:0] TAG_LIVE = 2'd1;
	localparam logic [1:0] TAG_TOMB = 2'd2;

	localparam logic [2:0] ST_NEW = 3'd0;
	localparam logic [2:0] ST_UPDATED = 3'd1;
	localparam logic [2:0] ST_FOUND = 3'd2;
	localparam logic [2:0] ST_NOT_FOUND = 3'd3;
	localparam logic [2:0] ST_DELETED = 3'd4;
	localparam logic [2:0] ST_FULL = 3'd5;

	localparam logic [31:0] HashSeed = 32'd5381;
	localparam logic [5:0] LoadLimitReset = 6'd42;

	typedef struct packed {
		logic [1:0] kind;
		logic [63:0] key;
		logic [31:0] value_in;
	} req_t;

	typedef struct packed {
		logic [2:0] status;
		logic [31:0] value_out;
	} rsp_t;
endpackage

/* design/oaht_req_if.sv */
// Valid/ready channel interface carrying one hash table request.
// Depends on oaht_pkg.
interface oaht_req_if;
	import oaht_pkg::*;
	logic valid;
	logic ready;
	req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* design/oaht_rsp_if.sv */
// Valid/ready channel interface carrying one hash table response.
// Depends on oaht_pkg.
interface oaht_rsp_if;
	import oaht_pkg::*;
	logic valid;
	logic ready;
	rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* design/oaht_cfg_if.sv */
// Valid/ready configuration write channel for the load limit register.
// No dependencies.
interface oaht_cfg_if;
	logic valid;
	logic ready;
	logic [5:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* design/open_address_hash_table.sv */
// Top level of the open-address hash table with its request sequencer.
// Depends on oaht_pkg, the channel interfaces and the assertion header.
//
// Usage: requests (kind, key, value_in) arrive on req, one response
// (status, value_out) leaves on rsp for each request, in order. The load
// limit register is to be written on cfg only while the block is idle; the
// block itself does not enforce this. A request walks the key bytes one
// per cycle through a shared multiply-add (h*33+b), up to 8 bytes and
// stopping at the first zero byte, then probes the bucket memory; each
// probe step is a read state (S_READ) then a compare state (S_CMP), for
// up to 72 probe steps, then a write state (S_DONE) and a response state.
// The block takes one request at a time and holds req.ready low meanwhile.
// The response sits in an output register; a stalled receiver holds it and
// the block takes no new request until it is accepted.
// Reset empties all buckets at once (tag flip-flops), clears the fill
// count and sets the load limit to 42. Key, hash and value memories are
// not cleared; only the contents of live buckets are ever used.
module open_address_hash_table (
	input logic clk,
	input logic arst_n,
	oaht_req_if.sink req,
	oaht_rsp_if.source rsp,
	oaht_cfg_if.sink cfg
);
	import oaht_pkg::*;
	`include "open_address_hash_table_assert.svh"

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_HASH = 3'd1;
	localparam logic [2:0] S_READ = 3'd2;
	localparam logic [2:0] S_CMP = 3'd3;
	localparam logic [2:0] S_DONE = 3'd4;
	localparam logic [2:0] S_RESP = 3'd5;

	logic [2:0] state_q;
	logic [1:0] kind_q;
	logic [63:0] raw_q;
	logic [63:0] canon_q;
	logic [31:0] value_q;
	logic [3:0] byte_q;
	logic [31:0] hash_q;
	logic [31:0] perturb_q;
	logic [IdxW-1:0] idx_q;
	logic [ProbeW-1:0] probes_q;
	logic hit_q, tomb_seen_q, empty_seen_q;
	logic [IdxW-1:0] hit_idx_q, tomb_idx_q, empty_idx_q;
	logic [FillW-1:0] filled_q;
	logic [5:0] limit_q;
	rsp_t rsp_q;
	logic [1:0] tag_q [TableSize];

	// Bucket memories, one write and one read port each, registered read.
	logic [31:0] mem_hash [TableSize];
	logic [63:0] mem_key [TableSize];
	logic [31:0] mem_val [TableSize];
	logic [31:0] rd_hash_q;
	logic [63:0] rd_key_q;
	logic [31:0] rd_val_q;
	logic [1:0] rd_tag_q;

	logic mem_we, val_we;
	logic [IdxW-1:0] wr_idx;
	logic [IdxW-1:0] rd_idx;

	assign req.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;
	assign rsp.valid = (state_q == S_RESP);
	assign rsp.data = rsp_q;

	// Shared hash step: h*33 + byte.
	logic [7:0] cur_byte;
	logic [31:0] hash_next;
	assign cur_byte = raw_q[7:0];
	assign hash_next = (hash_q << 5) + hash_q + {24'd0, cur_byte};

	// Next probe index and the effective limit.
	logic [31:0] perturb_next;
	logic [IdxW-1:0] idx_next;
	logic [5:0] eff_limit;
	assign perturb_next = perturb_q >> 5;
	assign idx_next = IdxW'((idx_q * 3'd5) + perturb_next[IdxW-1:0] + 1'b1);
	assign eff_limit = (limit_q < 6'(TableSize - 1)) ? limit_q : 6'(TableSize - 1);

	// Final decision of the request.
	logic ins_new_ok;
	logic [IdxW-1:0] ins_slot;
	assign ins_new_ok = !hit_q && (FillW'(eff_limit) > filled_q)
		&& (tomb_seen_q || empty_seen_q);
	assign ins_slot = tomb_seen_q ? tomb_idx_q : empty_idx_q;
	assign mem_we = (state_q == S_DONE) && (kind_q == KIND_INSERT) && ins_new_ok;
	assign val_we = (state_q == S_DONE) && (kind_q == KIND_INSERT)
		&& (hit_q || ins_new_ok);
	assign wr_idx = hit_q ? hit_idx_q : ins_slot;
	assign rd_idx = hit_q ? hit_idx_q : idx_q;

	// Memory write and registered read.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_hash[wr_idx] <= hash_q;
			mem_key[wr_idx] <= canon_q;
		end
		if (val_we) begin
			mem_val[wr_idx] <= value_q;
		end
		rd_hash_q <= mem_hash[idx_q];
		rd_key_q <= mem_key[idx_q];
		rd_val_q <= mem_val[rd_idx];
		rd_tag_q <= tag_q[idx_q];
	end

	// Tag flip-flops cleared at reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TableSize; i++) tag_q[i] <= TAG_EMPTY;
		end else if (state_q == S_DONE) begin
			if (mem_we) tag_q[wr_idx] <= TAG_LIVE;
			else if (kind_q == KIND_DELETE && hit_q) tag_q[hit_idx_q] <= TAG_TOMB;
		end
	end

	// Load limit register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LoadLimitReset;
		end else if (cfg.valid) begin
			limit_q <= cfg.data;
		end
	end

	// Request sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			filled_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req.valid) state_q <= S_HASH;
				end
				S_HASH: begin
					if (cur_byte == 8'd0 || byte_q == 4'd8) state_q <= S_READ;
				end
				S_READ: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (rd_tag_q == TAG_EMPTY) state_q <= S_DONE;
					else if (rd_tag_q == TAG_LIVE && rd_hash_q == hash_q
						&& rd_key_q == canon_q) state_q <= S_DONE;
					else if (probes_q == ProbeW'(ProbeLimit - 1)) state_q <= S_DONE;
					else state_q <= S_READ;
				end
				S_DONE: begin
					if (mem_we && !tomb_seen_q) filled_q <= filled_q + 1'b1;
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (rsp.ready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers of the request.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				kind_q <= req.data.kind;
				raw_q <= req.data.key;
				value_q <= req.data.value_in;
				canon_q <= '0;
				byte_q <= '0;
				hash_q <= HashSeed;
				hit_q <= 1'b0;
				tomb_seen_q <= 1'b0;
				empty_seen_q <= 1'b0;
				probes_q <= '0;
			end
			S_HASH: begin
				if (!(cur_byte == 8'd0 || byte_q == 4'd8)) begin
					hash_q <= hash_next;
					canon_q <= canon_q | ({56'd0, cur_byte} << {byte_q[2:0], 3'd0});
					raw_q <= raw_q >> 8;
					byte_q <= byte_q + 1'b1;
				end else begin
					perturb_q <= hash_q;
					idx_q <= hash_q[IdxW-1:0];
				end
			end
			S_CMP: begin
				if (rd_tag_q == TAG_EMPTY) begin
					empty_seen_q <= 1'b1;
					empty_idx_q <= idx_q;
				end else if (rd_tag_q == TAG_LIVE && rd_hash_q == hash_q
					&& rd_key_q == canon_q) begin
					hit_q <= 1'b1;
					hit_idx_q <= idx_q;
				end else begin
					if (rd_tag_q == TAG_TOMB && !tomb_seen_q) begin
						tomb_seen_q <= 1'b1;
						tomb_idx_q <= idx_q;
					end
					perturb_q <= perturb_next;
					idx_q <= idx_next;
					probes_q <= probes_q + 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// Response register; lookup value is read through the hit index.
	always_ff @(posedge clk) begin
		if (state_q == S_DONE) begin
			rsp_q.value_out <= '0;
			case (kind_q)
				KIND_INSERT: rsp_q.status <= hit_q ? ST_UPDATED
					: (ins_new_ok ? ST_NEW : ST_FULL);
				KIND_LOOKUP: begin
					rsp_q.status <= hit_q ? ST_FOUND : ST_NOT_FOUND;
					if (hit_q) rsp_q.value_out <= rd_val_q;
				end
				KIND_DELETE: rsp_q.status <= hit_q ? ST_DELETED : ST_NOT_FOUND;
				default: rsp_q.status <= ST_NOT_FOUND;
			endcase
		end
	end

	// rd_val_q is valid in S_DONE as idx_q and then rd_idx stay on the hit bucket.
	`OAHT_ASSERT_IMP(a_fill_bound, clk, arst_n, 1'b1, filled_q <= FillW'(TableSize - 1))
	`OAHT_ASSERT_IMP(a_busy_not_ready, clk, arst_n, state_q != S_IDLE, !req.ready)
	`OAHT_ASSERT_NEXT(a_resp_held, clk, arst_n, rsp.valid && !rsp.ready,
		rsp.valid && $stable(rsp_q))
	`OAHT_ASSERT_IMP(a_write_live_only, clk, arst_n, mem_we, !hit_q)
endmodule
